FILE: hdl/docking_phase_sequencer_core_assert.svh
// assertion macros shared by the sequencer modules
`ifndef DOCKING_PHASE_SEQUENCER_CORE_ASSERT_SVH
`define DOCKING_PHASE_SEQUENCER_CORE_ASSERT_SVH

// same-cycle implication
`define DPS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define DPS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hdl/dps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_pkg
// types, codes and constants of the docking phase sequencer
// ----------------------------------------------------------------------------
package dps_pkg;

   localparam int MUL_W  = 25;
   localparam int PROD_W = 50;
   localparam int ACC_W  = 51;
   localparam int SQ_W   = 50;
   localparam int DSQ_W  = 46;
   localparam int PROJ_W = 44;
   localparam int NSQ_W  = 48;
   localparam int ROOT_W = 24;
   localparam int U_W    = 18;
   localparam int Q_W    = 17;
   localparam int DREM_W = 25;
   localparam int IDX_W  = 5;

   localparam logic [IDX_W-1:0] MUL_NSQ_LAST = 5'd1;
   localparam logic [IDX_W-1:0] MUL_FIRST_PROJ = 5'd2;
   localparam logic [IDX_W-1:0] MUL_LAST = 5'd17;
   localparam logic [4:0] SQRT_LAST = 5'd23;
   localparam logic [4:0] DIV_LAST = 5'd16;
   localparam logic [24:0] NORM_LIMIT = 25'd4194304;
   localparam logic [22:0] UNSET_DIST = 23'h7FFFFF;

   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;

   localparam logic [2:0] PH_IDLE      = 3'd0;
   localparam logic [2:0] PH_TAKEOFF   = 3'd1;
   localparam logic [2:0] PH_APPROACH  = 3'd2;
   localparam logic [2:0] PH_TRACKING  = 3'd3;
   localparam logic [2:0] PH_DOCKING   = 3'd4;
   localparam logic [2:0] PH_COMPLETED = 3'd5;

   localparam logic [2:0] CSR_APPROACH = 3'd0;
   localparam logic [2:0] CSR_TRACKING = 3'd1;
   localparam logic [2:0] CSR_DOCKING  = 3'd2;
   localparam logic [2:0] CSR_SPEED    = 3'd3;
   localparam logic [2:0] CSR_HOVER    = 3'd4;
   localparam logic [2:0] CSR_TERMINAL = 3'd5;
   localparam logic [2:0] CSR_PASSIVE  = 3'd6;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_ADD  = 2'd1,
      OP_SUB  = 2'd2
   } acc_op_type;

   typedef struct packed {
      logic [1:0]         func;
      logic signed [23:0] rel_pos_x;
      logic signed [23:0] rel_pos_y;
      logic signed [23:0] rel_pos_z;
      logic signed [23:0] rel_vel_x;
      logic signed [23:0] rel_vel_y;
      logic signed [23:0] rel_vel_z;
      logic signed [23:0] target_vel_x;
      logic signed [23:0] target_vel_y;
      logic signed [23:0] carrier_alt;
      logic signed [23:0] target_alt;
      logic [22:0]        rel_distance;
   } req_type;

   typedef struct packed {
      logic [22:0]        approach_distance;
      logic [22:0]        tracking_distance;
      logic [22:0]        docking_distance;
      logic [22:0]        speed_threshold;
      logic signed [23:0] hover_altitude;
      logic signed [23:0] terminal_height;
      logic               passive_mode;
   } cfg_type;

   typedef struct packed {
      logic window;
      logic rigid;
      logic gentle;
      logic capture;
      logic complete;
   } flags_type;

   function automatic acc_op_type mul_op(input logic [IDX_W-1:0] idx);
      acc_op_type op;
      unique case (idx)
         5'd0, 5'd2, 5'd5, 5'd8, 5'd10, 5'd12, 5'd14, 5'd16, 5'd17: op = OP_LOAD;
         5'd11, 5'd15: op = OP_SUB;
         default: op = OP_ADD;
      endcase
      return op;
   endfunction

   function automatic logic [15:0] sat_inc(input logic [15:0] c);
      return (c == 16'hFFFF) ? c : c + 16'd1;
   endfunction

   function automatic logic signed [PROJ_W-1:0] q28(input int c);
      return PROJ_W'(longint'(c) * 64'sd65536);
   endfunction

   function automatic logic band44(input logic signed [PROJ_W-1:0] x,
                                   input logic signed [PROJ_W-1:0] c);
      return (x > -c) && (x < c);
   endfunction

   function automatic logic band25(input logic signed [24:0] x, input logic signed [24:0] c);
      return (x > -c) && (x < c);
   endfunction

endpackage

FILE: hdl/dps_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_req_if
// request channel: command and one control tick of measurements
// ----------------------------------------------------------------------------
interface dps_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         func;
   logic signed [23:0] rel_pos_x;
   logic signed [23:0] rel_pos_y;
   logic signed [23:0] rel_pos_z;
   logic signed [23:0] rel_vel_x;
   logic signed [23:0] rel_vel_y;
   logic signed [23:0] rel_vel_z;
   logic signed [23:0] target_vel_x;
   logic signed [23:0] target_vel_y;
   logic signed [23:0] carrier_alt;
   logic signed [23:0] target_alt;
   logic [22:0]        rel_distance;

   modport source (
      output valid, func, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y,
             rel_vel_z, target_vel_x, target_vel_y, carrier_alt, target_alt,
             rel_distance,
      input  ready
   );
   modport sink (
      input  valid, func, rel_pos_x, rel_pos_y, rel_pos_z, rel_vel_x, rel_vel_y,
             rel_vel_z, target_vel_x, target_vel_y, carrier_alt, target_alt,
             rel_distance,
      output ready
   );
endinterface

FILE: hdl/dps_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_rsp_if
// response channel: phase, run flag and closest docking distance
// ----------------------------------------------------------------------------
interface dps_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  phase;
   logic        docking_active;
   logic [22:0] closest_distance;

   modport source (output valid, phase, docking_active, closest_distance, input ready);
   modport sink (input valid, phase, docking_active, closest_distance, output ready);
endinterface

FILE: hdl/dps_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dps_calc
// capture window evaluation on one shared multiplier, serial root and divider
// ----------------------------------------------------------------------------
`include "docking_phase_sequencer_core_assert.svh"

module dps_calc import dps_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  req_type   req,
   input  cfg_type   cfg,
   output logic      done,
   output flags_type flags
);

   typedef enum logic [5:0] {
      C_IDLE = 6'b000001,
      C_NORM = 6'b000010,
      C_MUL  = 6'b000100,
      C_SQRT = 6'b001000,
      C_DIV  = 6'b010000,
      C_EVAL = 6'b100000
   } calc_state_type;

   calc_state_type state_ff, state_in;

   logic signed [24:0]        ez_ff, ez_in;
   logic signed [24:0]        tx_ff, tx_in, ty_ff, ty_in;
   logic signed [U_W-1:0]     ux_ff, ux_in, uy_ff, uy_in;
   logic signed [PROD_W-1:0]  prod_ff, prod_in;
   logic signed [ACC_W-1:0]   acc_ff, acc_in;
   logic [IDX_W-1:0]          idx_ff, idx_in;
   logic                      ph_ff, ph_in;
   logic [SQ_W-1:0]           err2_ff, err2_in, rv2_ff, rv2_in;
   logic signed [PROJ_W-1:0]  along_ff, along_in, lat_ff, lat_in;
   logic signed [PROJ_W-1:0]  alongs_ff, alongs_in, lats_ff, lats_in;
   logic [DSQ_W-1:0]          dd2_ff, dd2_in, sp2_ff, sp2_in;
   logic [NSQ_W-1:0]          sq_ff, sq_in;
   logic [25:0]               rem_ff, rem_in;
   logic [ROOT_W-1:0]         root_ff, root_in;
   logic [4:0]                cnt_ff, cnt_in;
   logic                      dsel_ff, dsel_in;
   logic [Q_W-1:0]            q_ff, q_in;
   logic [DREM_W-1:0]         drem_ff, drem_in;
   logic                      done_ff, done_in;
   flags_type                 flags_ff, flags_in;

   logic signed [MUL_W-1:0]   op_a, op_b;
   logic signed [ACC_W-1:0]   acc_next;
   logic signed [24:0]        tx0, ty0, px_e, py_e;
   logic [24:0]               atx, aty;
   logic [27:0]               rem2, trial;
   logic [25:0]               cand;
   logic                      qbit;
   logic [Q_W-1:0]            q_next;
   logic signed [U_W-1:0]     u_res;
   logic [55:0]               err25, dd64;
   logic                      near_cap;

   assign px_e = {req.rel_pos_x[23], req.rel_pos_x};
   assign py_e = {req.rel_pos_y[23], req.rel_pos_y};
   assign tx0  = (req.target_vel_x == '0 && req.target_vel_y == '0) ? -px_e
                 : {req.target_vel_x[23], req.target_vel_x};
   assign ty0  = (req.target_vel_x == '0 && req.target_vel_y == '0) ? -py_e
                 : {req.target_vel_y[23], req.target_vel_y};
   assign atx  = tx_ff[24] ? 25'(-tx_ff) : 25'(tx_ff);
   assign aty  = ty_ff[24] ? 25'(-ty_ff) : 25'(ty_ff);

   // operand schedule of the shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      unique case (idx_ff)
         5'd0:  begin op_a = tx_ff; op_b = tx_ff; end
         5'd1:  begin op_a = ty_ff; op_b = ty_ff; end
         5'd2:  begin op_a = px_e; op_b = px_e; end
         5'd3:  begin op_a = py_e; op_b = py_e; end
         5'd4:  begin op_a = ez_ff; op_b = ez_ff; end
         5'd5:  begin
            op_a = {req.rel_vel_x[23], req.rel_vel_x};
            op_b = {req.rel_vel_x[23], req.rel_vel_x};
         end
         5'd6:  begin
            op_a = {req.rel_vel_y[23], req.rel_vel_y};
            op_b = {req.rel_vel_y[23], req.rel_vel_y};
         end
         5'd7:  begin
            op_a = {req.rel_vel_z[23], req.rel_vel_z};
            op_b = {req.rel_vel_z[23], req.rel_vel_z};
         end
         5'd8:  begin op_a = px_e; op_b = MUL_W'(ux_ff); end
         5'd9:  begin op_a = py_e; op_b = MUL_W'(uy_ff); end
         5'd10: begin op_a = py_e; op_b = MUL_W'(ux_ff); end
         5'd11: begin op_a = px_e; op_b = MUL_W'(uy_ff); end
         5'd12: begin op_a = {req.rel_vel_x[23], req.rel_vel_x}; op_b = MUL_W'(ux_ff); end
         5'd13: begin op_a = {req.rel_vel_y[23], req.rel_vel_y}; op_b = MUL_W'(uy_ff); end
         5'd14: begin op_a = {req.rel_vel_y[23], req.rel_vel_y}; op_b = MUL_W'(ux_ff); end
         5'd15: begin op_a = {req.rel_vel_x[23], req.rel_vel_x}; op_b = MUL_W'(uy_ff); end
         5'd16: begin
            op_a = {2'b00, cfg.docking_distance};
            op_b = {2'b00, cfg.docking_distance};
         end
         5'd17: begin
            op_a = {2'b00, cfg.speed_threshold};
            op_b = {2'b00, cfg.speed_threshold};
         end
         default: begin op_a = '0; op_b = '0; end
      endcase
   end

   always_comb begin
      unique case (mul_op(idx_ff))
         OP_LOAD: acc_next = ACC_W'(prod_ff);
         OP_SUB:  acc_next = acc_ff - ACC_W'(prod_ff);
         default: acc_next = acc_ff + ACC_W'(prod_ff);
      endcase
   end

   // one root step and one divide step
   assign rem2  = {rem_ff, sq_ff[NSQ_W-1 -: 2]};
   assign trial = {2'b00, root_ff, 2'b01};
   assign cand  = (cnt_ff == '0) ? {1'b0, drem_ff} : {drem_ff, 1'b0};
   assign qbit  = cand >= {2'b00, root_ff};
   assign q_next = {q_ff[Q_W-2:0], qbit};
   assign u_res = (dsel_ff ? ty_ff[24] : tx_ff[24]) ? -U_W'({1'b0, q_next})
                  : U_W'({1'b0, q_next});

   assign err25 = {6'b0, err2_ff} + {2'b0, err2_ff, 4'b0} + {3'b0, err2_ff, 3'b0};
   assign dd64  = {4'b0, dd2_ff, 6'b0};
   assign near_cap = err2_ff < SQ_W'(737 * 737) && along_ff > -q28(492) &&
                     along_ff < q28(492) && band44(lat_ff, q28(573)) &&
                     band25(ez_ff, 25'sd328);

   always_comb begin
      state_in  = state_ff;
      ez_in     = ez_ff;
      tx_in     = tx_ff;
      ty_in     = ty_ff;
      ux_in     = ux_ff;
      uy_in     = uy_ff;
      prod_in   = prod_ff;
      acc_in    = acc_ff;
      idx_in    = idx_ff;
      ph_in     = ph_ff;
      err2_in   = err2_ff;
      rv2_in    = rv2_ff;
      along_in  = along_ff;
      lat_in    = lat_ff;
      alongs_in = alongs_ff;
      lats_in   = lats_ff;
      dd2_in    = dd2_ff;
      sp2_in    = sp2_ff;
      sq_in     = sq_ff;
      rem_in    = rem_ff;
      root_in   = root_ff;
      cnt_in    = cnt_ff;
      dsel_in   = dsel_ff;
      q_in      = q_ff;
      drem_in   = drem_ff;
      done_in   = 1'b0;
      flags_in  = flags_ff;
      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               ez_in = {req.rel_pos_z[23], req.rel_pos_z} -
                       {cfg.terminal_height[23], cfg.terminal_height};
               tx_in = tx0;
               ty_in = ty0;
               ph_in = 1'b0;
               if (tx0 == '0 && ty0 == '0) begin
                  // unit x fallback
                  ux_in    = U_W'(65536);
                  uy_in    = '0;
                  idx_in   = MUL_FIRST_PROJ;
                  state_in = C_MUL;
               end else begin
                  idx_in   = '0;
                  state_in = C_NORM;
               end
            end
         end
         C_NORM: begin
            if (atx < NORM_LIMIT && aty < NORM_LIMIT) begin
               tx_in = tx_ff <<< 1;
               ty_in = ty_ff <<< 1;
            end else begin
               state_in = C_MUL;
            end
         end
         C_MUL: begin
            if (!ph_ff) begin
               prod_in = op_a * op_b;
               ph_in   = 1'b1;
            end else begin
               acc_in = acc_next;
               ph_in  = 1'b0;
               idx_in = idx_ff + 5'd1;
               unique case (idx_ff)
                  5'd1:  sq_in = acc_next[NSQ_W-1:0];
                  5'd4:  err2_in = acc_next[SQ_W-1:0];
                  5'd7:  rv2_in = acc_next[SQ_W-1:0];
                  5'd9:  along_in = acc_next[PROJ_W-1:0];
                  5'd11: lat_in = acc_next[PROJ_W-1:0];
                  5'd13: alongs_in = acc_next[PROJ_W-1:0];
                  5'd15: lats_in = acc_next[PROJ_W-1:0];
                  5'd16: dd2_in = acc_next[DSQ_W-1:0];
                  5'd17: sp2_in = acc_next[DSQ_W-1:0];
                  default: ;
               endcase
               if (idx_ff == MUL_NSQ_LAST) begin
                  rem_in   = '0;
                  root_in  = '0;
                  cnt_in   = '0;
                  state_in = C_SQRT;
               end else if (idx_ff == MUL_LAST) begin
                  state_in = C_EVAL;
               end
            end
         end
         C_SQRT: begin
            sq_in = sq_ff << 2;
            if (rem2 >= trial) begin
               rem_in  = 26'(rem2 - trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem2[25:0];
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == SQRT_LAST) begin
               cnt_in   = '0;
               dsel_in  = 1'b0;
               q_in     = '0;
               drem_in  = atx;
               state_in = C_DIV;
            end
         end
         C_DIV: begin
            q_in    = q_next;
            drem_in = qbit ? DREM_W'(cand - {2'b00, root_ff}) : cand[DREM_W-1:0];
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == DIV_LAST) begin
               cnt_in = '0;
               q_in   = '0;
               if (!dsel_ff) begin
                  ux_in   = u_res;
                  dsel_in = 1'b1;
                  drem_in = aty;
               end else begin
                  uy_in    = u_res;
                  idx_in   = MUL_FIRST_PROJ;
                  ph_in    = 1'b0;
                  state_in = C_MUL;
               end
            end
         end
         C_EVAL: begin
            flags_in.window = (err25 < dd64 || err2_ff < SQ_W'(7782 * 7782)) &&
                              band44(lat_ff, q28(5939)) && along_ff > q28(819) &&
                              along_ff < q28(11469) && req.rel_pos_z > 24'sd2458 &&
                              req.rel_pos_z < 24'sd5530 && band44(lats_ff, q28(9830));
            flags_in.rigid = err2_ff < SQ_W'(573 * 573) && band44(along_ff, q28(410)) &&
                             band44(lat_ff, q28(410)) && band25(ez_ff, 25'sd328) &&
                             band44(alongs_ff, q28(1843)) && band44(lats_ff, q28(1843)) &&
                             band25({req.rel_vel_z[23], req.rel_vel_z}, 25'sd1638);
            flags_in.gentle = near_cap && band44(alongs_ff, q28(2458)) &&
                              band44(lats_ff, q28(2458)) &&
                              band25({req.rel_vel_z[23], req.rel_vel_z}, 25'sd1434);
            flags_in.capture = near_cap && band44(alongs_ff, q28(2662)) &&
                               band44(lats_ff, q28(2662)) &&
                               band25({req.rel_vel_z[23], req.rel_vel_z}, 25'sd1434);
            flags_in.complete = err2_ff < {4'b0, dd2_ff} && err2_ff < SQ_W'(819 * 819) &&
                                rv2_ff < {4'b0, sp2_ff};
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
         ph_ff    <= 1'b0;
         idx_ff   <= '0;
         cnt_ff   <= '0;
         dsel_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
         ph_ff    <= ph_in;
         idx_ff   <= idx_in;
         cnt_ff   <= cnt_in;
         dsel_ff  <= dsel_in;
      end
   end

   always_ff @(posedge clock) begin
      ez_ff     <= ez_in;
      tx_ff     <= tx_in;
      ty_ff     <= ty_in;
      ux_ff     <= ux_in;
      uy_ff     <= uy_in;
      prod_ff   <= prod_in;
      acc_ff    <= acc_in;
      err2_ff   <= err2_in;
      rv2_ff    <= rv2_in;
      along_ff  <= along_in;
      lat_ff    <= lat_in;
      alongs_ff <= alongs_in;
      lats_ff   <= lats_in;
      dd2_ff    <= dd2_in;
      sp2_ff    <= sp2_in;
      sq_ff     <= sq_in;
      rem_ff    <= rem_in;
      root_ff   <= root_in;
      q_ff      <= q_in;
      drem_ff   <= drem_in;
      flags_ff  <= flags_in;
   end

   assign done  = done_ff;
   assign flags = flags_ff;

   `DPS_ASSERT_NOW(a_div_nonzero, clock, reset, state_ff == C_DIV, root_ff != '0, "divide by zero root")
   `DPS_ASSERT_NEXT(a_done_pulse, clock, reset, done_ff, !done_ff && state_ff == C_IDLE, "done not a single pulse")
   `DPS_ASSERT_NOW(a_start_idle, clock, reset, start, state_ff == C_IDLE, "start while busy")

endmodule

FILE: hdl/docking_phase_sequencer_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// docking_phase_sequencer_core
// phase sequencer for a two-vehicle docking run
// ----------------------------------------------------------------------------
// One request at a time. Start, stop and ticks taken while no run is active
// go straight to the apply state and respond from there; the next request is
// taken only after the response is loaded. A tick during a run goes through
// the capture window unit: one 25x25 multiplier shared over 18 products, a
// 24-step square root and two 17-step divisions for the track direction,
// plus up to 22 doubling steps. A tick whose track and horizontal error are
// both zero uses unit x and skips the doubling, the root and the divisions.
// A response may wait in its output register while the next request is taken.
`include "docking_phase_sequencer_core_assert.svh"

module docking_phase_sequencer_core import dps_pkg::*; #(
   parameter int CONTROL_RATE = 50
) (
   input  logic        clock,
   input  logic        reset,
   dps_req_if.sink     req_chan,
   dps_rsp_if.source   rsp_chan,
   input  logic        csr_wr_en,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_wdata
);

   localparam int COMP_RAW   = CONTROL_RATE * 35 / 100;
   localparam int COMP_STEPS = (COMP_RAW < 1) ? 1 : COMP_RAW;
   localparam int CAPT_RAW   = CONTROL_RATE * 6 / 100;
   localparam int CAPT_STEPS = (CAPT_RAW < 2) ? 2 : CAPT_RAW;
   localparam int REL_STEPS  = CONTROL_RATE * 4 / 5;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_CALC  = 3'b010,
      ST_APPLY = 3'b100
   } top_state_type;

   top_state_type state_ff, state_in;
   req_type     req_ff;
   cfg_type     cfg_ff;
   logic [2:0]  phase_ff, phase_in;
   logic        active_ff, active_in;
   logic [15:0] dock_ff, dock_in, comp_ff, comp_in, capt_ff, capt_in;
   logic [22:0] min_ff, min_in;
   logic        start_ff;
   logic        rsp_valid_ff;
   logic [2:0]  rsp_phase_ff;
   logic        rsp_active_ff;
   logic [22:0] rsp_dist_ff;

   logic        accept, slot_free, calc_done;
   flags_type   flags;
   logic [22:0] rel_dist, min_upd;
   logic [15:0] dock_inc, comp_inc, capt_inc;
   logic [26:0] dist5, ad6, td12;
   logic signed [24:0] calt_err, talt_err;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign accept    = req_chan.valid && req_chan.ready;
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;

   dps_calc u_calc (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .req   (req_ff),
      .cfg   (cfg_ff),
      .done  (calc_done),
      .flags (flags)
   );

   assign rel_dist = req_ff.rel_distance;
   assign min_upd  = (rel_dist < min_ff) ? rel_dist : min_ff;
   assign dock_inc = sat_inc(dock_ff);
   assign comp_inc = (flags.complete || flags.capture) ? sat_inc(comp_ff) : '0;
   assign capt_inc = flags.capture ? sat_inc(capt_ff) : '0;
   assign dist5    = ({4'b0, rel_dist} << 2) + {4'b0, rel_dist};
   assign ad6      = ({4'b0, cfg_ff.approach_distance} << 2) +
                     ({4'b0, cfg_ff.approach_distance} << 1);
   assign td12     = ({4'b0, cfg_ff.tracking_distance} << 3) +
                     ({4'b0, cfg_ff.tracking_distance} << 2);
   assign calt_err = {req_ff.carrier_alt[23], req_ff.carrier_alt} -
                     {cfg_ff.hover_altitude[23], cfg_ff.hover_altitude};
   assign talt_err = {req_ff.target_alt[23], req_ff.target_alt} -
                     {cfg_ff.hover_altitude[23], cfg_ff.hover_altitude};

   // phase update for the held request
   always_comb begin
      phase_in  = phase_ff;
      active_in = active_ff;
      dock_in   = dock_ff;
      comp_in   = comp_ff;
      capt_in   = capt_ff;
      min_in    = min_ff;
      unique case (req_ff.func)
         FUNC_START: begin
            if (!active_ff) begin
               active_in = 1'b1;
               phase_in  = cfg_ff.passive_mode ? PH_APPROACH : PH_TAKEOFF;
               dock_in   = '0;
               comp_in   = '0;
               capt_in   = '0;
               min_in    = UNSET_DIST;
            end
         end
         FUNC_STOP: begin
            active_in = 1'b0;
            phase_in  = PH_IDLE;
            dock_in   = '0;
            comp_in   = '0;
            capt_in   = '0;
            min_in    = UNSET_DIST;
         end
         FUNC_TICK: begin
            if (active_ff) begin
               unique case (phase_ff)
                  PH_TAKEOFF: begin
                     dock_in = '0;
                     comp_in = '0;
                     capt_in = '0;
                     if (band25(calt_err, 25'sd614) &&
                         (cfg_ff.passive_mode || band25(talt_err, 25'sd614)))
                        phase_in = PH_APPROACH;
                  end
                  PH_APPROACH: begin
                     dock_in = '0;
                     comp_in = '0;
                     capt_in = '0;
                     if (rel_dist < cfg_ff.approach_distance) phase_in = PH_TRACKING;
                  end
                  PH_TRACKING: begin
                     dock_in = '0;
                     comp_in = '0;
                     capt_in = '0;
                     if ((cfg_ff.passive_mode && flags.window) ||
                         (!cfg_ff.passive_mode && rel_dist < cfg_ff.tracking_distance)) begin
                        phase_in = PH_DOCKING;
                        min_in   = rel_dist;
                     end else if (dist5 > ad6) begin
                        phase_in = PH_APPROACH;
                     end
                  end
                  PH_DOCKING: begin
                     dock_in = dock_inc;
                     min_in  = min_upd;
                     comp_in = comp_inc;
                     capt_in = capt_inc;
                     if (comp_inc >= 16'(COMP_STEPS) || capt_inc >= 16'(CAPT_STEPS) ||
                         (cfg_ff.passive_mode && (flags.rigid || flags.gentle))) begin
                        phase_in = PH_COMPLETED;
                     end else if (dock_inc > 16'(REL_STEPS) && dist5 > td12 &&
                                  rel_dist > 23'd73728 &&
                                  {1'b0, rel_dist} > {1'b0, min_upd} + 24'd24576) begin
                        // drifted away, back to tracking
                        phase_in = PH_TRACKING;
                        dock_in  = '0;
                        comp_in  = '0;
                        capt_in  = '0;
                     end
                  end
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept)
               state_in = (req_chan.func == FUNC_TICK && active_ff) ? ST_CALC : ST_APPLY;
         end
         ST_CALC:  if (calc_done) state_in = ST_APPLY;
         ST_APPLY: if (slot_free) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         start_ff     <= 1'b0;
         phase_ff     <= PH_IDLE;
         active_ff    <= 1'b0;
         dock_ff      <= '0;
         comp_ff      <= '0;
         capt_ff      <= '0;
         min_ff       <= UNSET_DIST;
         rsp_valid_ff <= 1'b0;
         cfg_ff.approach_distance <= 23'd20480;
         cfg_ff.tracking_distance <= 23'd8192;
         cfg_ff.docking_distance  <= 23'd2048;
         cfg_ff.speed_threshold   <= 23'd3277;
         cfg_ff.hover_altitude    <= 24'sd6144;
         cfg_ff.terminal_height   <= 24'sd819;
         cfg_ff.passive_mode      <= 1'b0;
      end else begin
         state_ff <= state_in;
         start_ff <= accept && req_chan.func == FUNC_TICK && active_ff;
         if (state_ff == ST_APPLY && slot_free) begin
            phase_ff     <= phase_in;
            active_ff    <= active_in;
            dock_ff      <= dock_in;
            comp_ff      <= comp_in;
            capt_ff      <= capt_in;
            min_ff       <= min_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_APPROACH: cfg_ff.approach_distance <= csr_wdata[22:0];
               CSR_TRACKING: cfg_ff.tracking_distance <= csr_wdata[22:0];
               CSR_DOCKING:  cfg_ff.docking_distance  <= csr_wdata[22:0];
               CSR_SPEED:    cfg_ff.speed_threshold   <= csr_wdata[22:0];
               CSR_HOVER:    cfg_ff.hover_altitude    <= csr_wdata;
               CSR_TERMINAL: cfg_ff.terminal_height   <= csr_wdata;
               CSR_PASSIVE:  cfg_ff.passive_mode      <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.func         <= req_chan.func;
         req_ff.rel_pos_x    <= req_chan.rel_pos_x;
         req_ff.rel_pos_y    <= req_chan.rel_pos_y;
         req_ff.rel_pos_z    <= req_chan.rel_pos_z;
         req_ff.rel_vel_x    <= req_chan.rel_vel_x;
         req_ff.rel_vel_y    <= req_chan.rel_vel_y;
         req_ff.rel_vel_z    <= req_chan.rel_vel_z;
         req_ff.target_vel_x <= req_chan.target_vel_x;
         req_ff.target_vel_y <= req_chan.target_vel_y;
         req_ff.carrier_alt  <= req_chan.carrier_alt;
         req_ff.target_alt   <= req_chan.target_alt;
         req_ff.rel_distance <= req_chan.rel_distance;
      end
      if (state_ff == ST_APPLY && slot_free) begin
         rsp_phase_ff  <= phase_in;
         rsp_active_ff <= active_in;
         rsp_dist_ff   <= min_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.phase            = rsp_phase_ff;
   assign rsp_chan.docking_active   = rsp_active_ff;
   assign rsp_chan.closest_distance = rsp_dist_ff;

   `DPS_ASSERT_NOW(a_idle_when_off, clock, reset, !active_ff, phase_ff == PH_IDLE, "phase set without a run")
   `DPS_ASSERT_NOW(a_done_in_calc, clock, reset, calc_done, state_ff == ST_CALC, "calc result outside calc")
   `DPS_ASSERT_NEXT(a_rsp_from_apply, clock, reset, state_ff == ST_APPLY && slot_free, rsp_valid_ff, "response not loaded")

endmodule
